### src/ctiot_pkg.sv
// ----------------------------------------------------------------------------
// ctiot_pkg
// shared types and codes for the console terminal interface
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctiot_pkg;

  // request kinds
  localparam logic [1:0] OP_KEY_IOT = 2'd0;
  localparam logic [1:0] OP_PRT_IOT = 2'd1;
  localparam logic [1:0] OP_KEY_RX  = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // keyboard iot pulses
  localparam logic [2:0] KP_CLR_FLAG  = 3'd0;
  localparam logic [2:0] KP_SKIP_FLAG = 3'd1;
  localparam logic [2:0] KP_CLR_AC    = 3'd2;
  localparam logic [2:0] KP_READ_OR   = 3'd4;
  localparam logic [2:0] KP_INT_EN    = 3'd5;
  localparam logic [2:0] KP_READ_CLR  = 3'd6;

  // printer iot pulses
  localparam logic [2:0] PP_SET_FLAG  = 3'd0;
  localparam logic [2:0] PP_SKIP_FLAG = 3'd1;
  localparam logic [2:0] PP_CLR_FLAG  = 3'd2;
  localparam logic [2:0] PP_LOAD      = 3'd4;
  localparam logic [2:0] PP_SKIP_IRQ  = 3'd5;
  localparam logic [2:0] PP_CLR_LOAD  = 3'd6;

  // configuration register indexes
  localparam logic CFG_UPPER_CASE = 1'b0;
  localparam logic CFG_PRINT_DLY  = 1'b1;

  localparam logic [15:0] PRINT_DELAY_RST = 16'd100;

  // character constants
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
  localparam logic [6:0] CHAR_CASE    = 7'h20;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  pulse;
    logic [11:0] ac;
    logic [7:0]  key_char;
  } item_t;

  typedef struct packed {
    logic [11:0] ac_out;
    logic        skip;
    logic        illegal_pulse;
    logic        irq;
    logic        print_valid;
    logic [6:0]  print_char;
  } result_t;

  typedef struct packed {
    logic        upper_case_only;
    logic [15:0] print_delay;
  } cfg_t;

endpackage

### src/ctiot_cfg.sv
// ----------------------------------------------------------------------------
// ctiot_cfg
// configuration registers: upper-case mapping and print delay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctiot_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output ctiot_pkg::cfg_t   cfg
);
  import ctiot_pkg::*;

  logic        upper_case_r;
  logic [15:0] print_delay_r;

  // always able to take a write
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_case_r  <= 1'b1;
      print_delay_r <= PRINT_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_UPPER_CASE: upper_case_r  <= cfg_data[0];
        CFG_PRINT_DLY:  print_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.upper_case_only = upper_case_r;
  assign cfg.print_delay     = print_delay_r;

endmodule

### src/ctiot_core.sv
// ----------------------------------------------------------------------------
// ctiot_core
// terminal state registers and the single-pass decode of one request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctiot_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctiot_pkg::cfg_t      cfg,
  input  logic                 fire,
  input  ctiot_pkg::item_t     item,
  output ctiot_pkg::result_t   res
);
  import ctiot_pkg::*;

  logic [7:0]  key_buffer_r,   key_buffer_nxt;
  logic        key_flag_r,     key_flag_nxt;
  logic        key_enable_r,   key_enable_nxt;
  logic [6:0]  print_buffer_r, print_buffer_nxt;
  logic        print_flag_r,   print_flag_nxt;
  logic        print_enable_r, print_enable_nxt;
  logic        print_busy_r,   print_busy_nxt;
  logic [15:0] print_cnt_r,    print_cnt_nxt;

  logic [6:0]  rx_char;
  logic        irq_cur;
  logic        start;

  assign irq_cur = (key_flag_r & key_enable_r) | (print_flag_r & print_enable_r);

  // received character with optional upper-case mapping
  always_comb begin
    rx_char = item.key_char[6:0];
    if (cfg.upper_case_only && rx_char >= CHAR_LOWER_A && rx_char <= CHAR_LOWER_Z)
      rx_char = rx_char - CHAR_CASE;
  end

  // request decode and next state
  always_comb begin
    key_buffer_nxt   = key_buffer_r;
    key_flag_nxt     = key_flag_r;
    key_enable_nxt   = key_enable_r;
    print_buffer_nxt = print_buffer_r;
    print_flag_nxt   = print_flag_r;
    print_enable_nxt = print_enable_r;
    print_busy_nxt   = print_busy_r;
    print_cnt_nxt    = print_cnt_r;
    start            = 1'b0;

    res.ac_out        = item.ac;
    res.skip          = 1'b0;
    res.illegal_pulse = 1'b0;
    res.print_valid   = 1'b0;
    res.print_char    = '0;

    unique case (item.opcode)
      OP_KEY_IOT: begin
        unique case (item.pulse)
          KP_CLR_FLAG:  key_flag_nxt = 1'b0;
          KP_SKIP_FLAG: res.skip = key_flag_r;
          KP_CLR_AC: begin
            key_flag_nxt = 1'b0;
            res.ac_out   = '0;
          end
          KP_READ_OR:   res.ac_out = item.ac | {4'b0, key_buffer_r};
          KP_INT_EN: begin
            key_enable_nxt   = item.ac[0];
            print_enable_nxt = item.ac[0];
          end
          KP_READ_CLR: begin
            key_flag_nxt = 1'b0;
            res.ac_out   = {4'b0, key_buffer_r};
          end
          default:      res.illegal_pulse = 1'b1;
        endcase
      end
      OP_PRT_IOT: begin
        unique case (item.pulse)
          PP_SET_FLAG:  print_flag_nxt = 1'b1;
          PP_SKIP_FLAG: res.skip = print_flag_r;
          PP_CLR_FLAG:  print_flag_nxt = 1'b0;
          PP_LOAD:      start = 1'b1;
          PP_SKIP_IRQ:  res.skip = irq_cur;
          PP_CLR_LOAD: begin
            print_flag_nxt = 1'b0;
            start          = 1'b1;
          end
          default:      res.illegal_pulse = 1'b1;
        endcase
      end
      OP_KEY_RX: begin
        key_buffer_nxt = {1'b1, rx_char};
        key_flag_nxt   = 1'b1;
      end
      OP_TICK: begin
        if (print_busy_r) begin
          if (print_cnt_r <= 16'd1) begin
            print_cnt_nxt   = '0;
            print_busy_nxt  = 1'b0;
            print_flag_nxt  = 1'b1;
            res.print_valid = 1'b1;
            res.print_char  = print_buffer_r;
          end else begin
            print_cnt_nxt = print_cnt_r - 16'd1;
          end
        end
      end
      default: ;
    endcase

    // load printer buffer; a busy printer keeps its countdown
    if (start) begin
      print_buffer_nxt = item.ac[6:0];
      if (!print_busy_r) begin
        print_busy_nxt = 1'b1;
        print_cnt_nxt  = cfg.print_delay;
      end
    end

    res.irq = (key_flag_nxt & key_enable_nxt) | (print_flag_nxt & print_enable_nxt);
  end

  // state update on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_buffer_r   <= '0;
      key_flag_r     <= 1'b0;
      key_enable_r   <= 1'b1;
      print_buffer_r <= '0;
      print_flag_r   <= 1'b0;
      print_enable_r <= 1'b1;
      print_busy_r   <= 1'b0;
      print_cnt_r    <= '0;
    end else if (fire) begin
      key_buffer_r   <= key_buffer_nxt;
      key_flag_r     <= key_flag_nxt;
      key_enable_r   <= key_enable_nxt;
      print_buffer_r <= print_buffer_nxt;
      print_flag_r   <= print_flag_nxt;
      print_enable_r <= print_enable_nxt;
      print_busy_r   <= print_busy_nxt;
      print_cnt_r    <= print_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // idle printer holds no count
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !print_busy_r |-> print_cnt_r == 16'd0)
    else $error("printer idle with nonzero countdown");

  // expiring tick raises the printer flag and frees the printer
  a_expire: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_TICK && print_busy_r && print_cnt_r <= 16'd1
    |=> print_flag_r && !print_busy_r)
    else $error("print expiry did not set flag");

  // received key sets flag and the marker bit
  a_key_rx: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_KEY_RX |=> key_flag_r && key_buffer_r[7])
    else $error("received key not latched");

  // character only emitted when the printer was busy
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.print_valid |-> print_busy_r && item.opcode == OP_TICK)
    else $error("character emitted without a print in progress");
`endif

endmodule

### src/console_terminal_iot_controller.sv
// ----------------------------------------------------------------------------
// console_terminal_iot_controller
// keyboard and printer interface of a 12-bit minicomputer console
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in_      in         in_valid / in_stall    opcode, pulse, ac, key_char
// out_     out        out_valid / out_stall  ac_out, skip, illegal_pulse, irq,
//                                            print_valid, print_char
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle while out_stall is low; input register, then result register
// each request is decoded and applied to the terminal state in one pass
// between the two registers
// reset is synchronous; cfg_ready is always high
// out_stall holds the result register; the input register still takes a
// request while it is empty, so in_stall rises only when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module console_terminal_iot_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_pulse,
  input  logic [11:0] in_ac,
  input  logic [7:0]  in_key_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_ac_out,
  output logic        out_skip,
  output logic        out_illegal_pulse,
  output logic        out_irq,
  output logic        out_print_valid,
  output logic [6:0]  out_print_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ctiot_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    adv;
  logic    in_take;

  // flow control
  assign adv      = item_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = item_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  ctiot_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (adv) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode   <= in_opcode;
      item_r.pulse    <= in_pulse;
      item_r.ac       <= in_ac;
      item_r.key_char <= in_key_char;
    end
  end

  ctiot_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (adv),
    .item  (item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ac_out        = res_r.ac_out;
  assign out_skip          = res_r.skip;
  assign out_illegal_pulse = res_r.illegal_pulse;
  assign out_irq           = res_r.irq;
  assign out_print_valid   = res_r.print_valid;
  assign out_print_char    = res_r.print_char;

`ifndef SYNTHESIS
  // an empty input register never pushes back
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |-> !in_stall)
    else $error("stall with empty input register");

  // a held result keeps the request in the input register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && item_valid_r |=> item_valid_r && out_valid_r)
    else $error("request lost while result held");

  // advancing a request always presents a result next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed request produced no result");
`endif

endmodule
